>>> hdl/bfr_pkg.sv
// Shared types, codes and the CRC function for the boot frame receiver.
// No dependencies; used by every module of the block.
`default_nettype none
package bfr_pkg;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register indexes (paddr[2])
  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic REG_MAX_IMAGE   = 1'b1;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd294912;
  localparam logic [31:0] MAX_IMAGE_RST   = 32'd458752;

  localparam logic [1:0] EV_NONE       = 2'd0;
  localparam logic [1:0] EV_PAYLOAD    = 2'd1;
  localparam logic [1:0] EV_HDR_OK     = 2'd2;
  localparam logic [1:0] EV_HDR_REJECT = 2'd3;

  localparam logic [1:0] CRC_NONE = 2'd0;
  localparam logic [1:0] CRC_GOOD = 2'd1;
  localparam logic [1:0] CRC_BAD  = 2'd2;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int QUEUE_DEPTH = 2;

  // one classified byte travelling from the front end to the back end
  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  crc_status;
    logic        last;
    logic [7:0]  payload_byte;
    logic [31:0] payload_offset;
    logic [31:0] payload_len;
    logic [31:0] image_len;
    logic [31:0] expected_crc;
  } cmd_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hdl/boot_frame_receiver_top.sv
// Boot frame receiver: takes one received byte per beat while in_stall is low and
// returns one result per byte. Bytes may arrive back to back while the queue has
// room; each byte passes through the two-entry command queue and then the output
// register. The rate is set by the back end's unrolled one-byte CRC-32 update,
// which is combinational. Writes to max_payload_len (address 0) and
// max_image_len (address 4) are checked at the end of each header.
// Depends on bfr_pkg, bfr_front, bfr_queue and bfr_back.
`default_nettype none
module boot_frame_receiver_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         event_res,
  output logic [1:0]                         crc_status,
  output logic [7:0]                         payload_byte,
  output logic [31:0]                        payload_offset,
  output logic [31:0]                        payload_len,
  output logic [31:0]                        image_len,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bfr_pkg::APB_AW-1:0]    paddr,
  input  wire logic [bfr_pkg::APB_DW-1:0]    pwdata,
  output logic [bfr_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  logic [31:0]    max_payload_len;
  logic [31:0]    max_image_len;
  logic           cfg_we;
  logic           reg_sel;
  logic           q_full, q_push, q_pop, q_valid;
  bfr_pkg::cmd_t  front_cmd, head_cmd;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= bfr_pkg::MAX_PAYLOAD_RST;
      max_image_len   <= bfr_pkg::MAX_IMAGE_RST;
    end else if (cfg_we) begin
      case (reg_sel)
        bfr_pkg::REG_MAX_PAYLOAD: max_payload_len <= pwdata;
        bfr_pkg::REG_MAX_IMAGE:   max_image_len   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bfr_pkg::REG_MAX_PAYLOAD: prdata = max_payload_len;
      bfr_pkg::REG_MAX_IMAGE:   prdata = max_image_len;
      default:                  prdata = '0;
    endcase
  end

  bfr_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .max_payload_len (max_payload_len),
    .max_image_len   (max_image_len),
    .q_full          (q_full),
    .push            (q_push),
    .cmd             (front_cmd)
  );

  bfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_cmd  (head_cmd)
  );

  bfr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_res      (event_res),
    .crc_status     (crc_status),
    .payload_byte   (payload_byte),
    .payload_offset (payload_offset),
    .payload_len    (payload_len),
    .image_len      (image_len)
  );

`ifndef SYNTHESIS
  // a verdict only comes with a payload beat or an accepted header
  a_verdict_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && crc_status != bfr_pkg::CRC_NONE |->
      (event_res == bfr_pkg::EV_PAYLOAD || event_res == bfr_pkg::EV_HDR_OK))
    else $error("crc verdict on a non-frame event");

  // a payload verdict lands on the last byte of the payload
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == bfr_pkg::EV_PAYLOAD && crc_status != bfr_pkg::CRC_NONE |->
      payload_offset == payload_len - 32'd1)
    else $error("crc verdict before the last payload byte");

  // nothing leaves the block in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

>>> hdl/bfr_front.sv
// Front end: magic hunt, header parse and payload tracking, one byte per beat
// while q_full is low. Depends on bfr_pkg; pushes one cmd_t per accepted byte.
`default_nettype none
module bfr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [31:0]   max_payload_len,
  input  wire logic [31:0]   max_image_len,
  input  wire logic          q_full,
  output logic               push,
  output bfr_pkg::cmd_t      cmd
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [31:0] MAGIC_WORD = 32'h4C42_5052;  // first byte in the low lane
  localparam logic [7:0]  MAGIC_FIRST = 8'h52;
  localparam logic [3:0]  HDR_BYTES = 4'd12;

  logic [1:0]  phase, phase_next;
  logic [1:0]  magic, magic_next;
  logic [3:0]  hcount, hcount_next, hidx_next;
  logic [31:0] length_word, len_next;
  logic [31:0] image_word, img_next;
  logic [31:0] expected_crc, exp_next;
  logic [31:0] bytes_received, brx_next;
  logic        mhit;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    phase_next  = phase;
    magic_next  = magic;
    hcount_next = hcount;
    len_next    = length_word;
    img_next    = image_word;
    exp_next    = expected_crc;
    brx_next    = bytes_received;
    cmd         = '0;
    hidx_next   = hcount + 4'd1;
    mhit        = rx_byte == MAGIC_WORD[{magic, 3'b000} +: 8];
    case (phase)
      PH_HEADER: begin
        if (hcount < 4'd4) begin
          len_next = {rx_byte, length_word[31:8]};
        end else if (hcount < 4'd8) begin
          img_next = {rx_byte, image_word[31:8]};
        end else begin
          exp_next = {rx_byte, expected_crc[31:8]};
        end
        hcount_next = hidx_next;
        if (hidx_next == HDR_BYTES) begin
          hcount_next     = 4'd0;
          magic_next      = 2'd0;
          cmd.payload_len = len_next;
          cmd.image_len   = img_next;
          if (len_next > max_payload_len || img_next > max_image_len) begin
            cmd.event_res = bfr_pkg::EV_HDR_REJECT;
            phase_next    = PH_HUNT;
          end else begin
            cmd.event_res = bfr_pkg::EV_HDR_OK;
            brx_next      = 32'd0;
            if (len_next == 32'd0) begin
              // empty payload: CRC of nothing is zero
              cmd.crc_status = (exp_next == 32'd0) ? bfr_pkg::CRC_GOOD : bfr_pkg::CRC_BAD;
              phase_next     = PH_HUNT;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        cmd.event_res      = bfr_pkg::EV_PAYLOAD;
        cmd.payload_byte   = rx_byte;
        cmd.payload_offset = bytes_received;
        cmd.payload_len    = length_word;
        cmd.image_len      = image_word;
        cmd.expected_crc   = expected_crc;
        brx_next           = bytes_received + 32'd1;
        if (brx_next == length_word) begin
          cmd.last   = 1'b1;
          phase_next = PH_HUNT;
          magic_next = 2'd0;
        end
      end
      default: begin
        if (mhit) begin
          if (magic == 2'd3) begin
            magic_next  = 2'd0;
            hcount_next = 4'd0;
            phase_next  = PH_HEADER;
          end else begin
            magic_next = magic + 2'd1;
          end
        end else begin
          // restart the match on a fresh first magic byte
          magic_next = (rx_byte == MAGIC_FIRST) ? 2'd1 : 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      magic          <= 2'd0;
      hcount         <= 4'd0;
      length_word    <= 32'd0;
      image_word     <= 32'd0;
      expected_crc   <= 32'd0;
      bytes_received <= 32'd0;
    end else if (push) begin
      phase          <= phase_next;
      magic          <= magic_next;
      hcount         <= hcount_next;
      length_word    <= len_next;
      image_word     <= img_next;
      expected_crc   <= exp_next;
      bytes_received <= brx_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/bfr_queue.sv
// Short command queue between the front end and the back end.
// Depends on bfr_pkg for cmd_t and the depth.
`default_nettype none
module bfr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bfr_pkg::cmd_t  push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output bfr_pkg::cmd_t       head_cmd
);

  localparam int DEPTH = bfr_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  bfr_pkg::cmd_t  slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full      = count == FULL_CNT;
  assign not_empty = count != '0;
  assign head_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/bfr_back.sv
// Back end: running CRC-32 over payload beats, verdict, output register.
// Depends on bfr_pkg for cmd_t, codes and crc_byte.
`default_nettype none
module bfr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire bfr_pkg::cmd_t  q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          event_res,
  output logic [1:0]          crc_status,
  output logic [7:0]          payload_byte,
  output logic [31:0]         payload_offset,
  output logic [31:0]         payload_len,
  output logic [31:0]         image_len
);

  logic [31:0] crc, crc_next;
  logic [1:0]  status_next;

  assign q_pop    = q_valid && (!out_valid || !out_stall);
  assign crc_next = bfr_pkg::crc_byte(crc, q_cmd.payload_byte);

  always_comb begin
    status_next = q_cmd.crc_status;
    if (q_cmd.last) begin
      status_next = ((~crc_next) == q_cmd.expected_crc) ? bfr_pkg::CRC_GOOD : bfr_pkg::CRC_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      crc       <= bfr_pkg::CRC_INIT;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        if (q_cmd.event_res == bfr_pkg::EV_HDR_OK) begin
          crc <= bfr_pkg::CRC_INIT;
        end else if (q_cmd.event_res == bfr_pkg::EV_PAYLOAD) begin
          crc <= crc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      event_res      <= q_cmd.event_res;
      crc_status     <= status_next;
      payload_byte   <= q_cmd.payload_byte;
      payload_offset <= q_cmd.payload_offset;
      payload_len    <= q_cmd.payload_len;
      image_len      <= q_cmd.image_len;
    end
  end

endmodule
`default_nettype wire

>>> bench/tb_boot_frame_receiver_top.sv
`timescale 1ns / 100ps
// Self-checking bench for boot_frame_receiver_top: byte driver, result monitor,
// APB register writes and an in-bench frame predictor. Depends on bfr_pkg.
module tb_boot_frame_receiver_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PRESSURE_AT = 250;
  localparam int HOLD_CYCLES = 200;
  localparam logic [31:0] MAGIC_WORD = 32'h4C42_5052;  // first byte in bits 7:0
  localparam logic [bfr_pkg::APB_AW-1:0] ADDR_MAX_PAYLOAD = {bfr_pkg::REG_MAX_PAYLOAD, 2'b00};
  localparam logic [bfr_pkg::APB_AW-1:0] ADDR_MAX_IMAGE   = {bfr_pkg::REG_MAX_IMAGE, 2'b00};

  typedef enum logic [1:0] {HUNT_MAGIC, READ_HEADER, TAKE_PAYLOAD} rx_phase_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  crc_status;
    logic [7:0]  payload_byte;
    logic [31:0] payload_offset;
    logic [31:0] payload_len;
    logic [31:0] image_len;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] event_res;
  logic [1:0] crc_status;
  logic [7:0] payload_byte;
  logic [31:0] payload_offset;
  logic [31:0] payload_len;
  logic [31:0] image_len;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bfr_pkg::APB_AW-1:0] paddr = '0;
  logic [bfr_pkg::APB_DW-1:0] pwdata = '0;
  logic [bfr_pkg::APB_DW-1:0] prdata;
  logic pready;

  // predictor state and its copy of the limits
  rx_phase_t   rx_phase = HUNT_MAGIC;
  int          magic_cnt = 0;
  int          hdr_count = 0;
  logic [31:0] plen_word = '0;
  logic [31:0] ilen_word = '0;
  logic [31:0] crc_word = '0;
  logic [31:0] crc_run = bfr_pkg::CRC_INIT;
  logic [31:0] byte_count = '0;
  logic [31:0] lim_payload = bfr_pkg::MAX_PAYLOAD_RST;
  logic [31:0] lim_image = bfr_pkg::MAX_IMAGE_RST;

  logic [7:0]    tx_bytes [$];
  frame_result_t due_results [$];
  int pushed = 0;
  int bytes_taken = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int src_gap = 0;
  int src_calm = 0;
  int snk_wait = 0;
  int snk_calm = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;

  boot_frame_receiver_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .crc_status(crc_status), .payload_byte(payload_byte),
    .payload_offset(payload_offset), .payload_len(payload_len), .image_len(image_len),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) r = r ^ bfr_pkg::CRC_POLY;
    end
    return r;
  endfunction

  function automatic frame_result_t receive_byte(input logic [7:0] b);
    frame_result_t r;
    r = '0;
    case (rx_phase)
      READ_HEADER: begin
        // little-endian words shift in from the top
        if (hdr_count < 4) plen_word = {b, plen_word[31:8]};
        else if (hdr_count < 8) ilen_word = {b, ilen_word[31:8]};
        else crc_word = {b, crc_word[31:8]};
        hdr_count = hdr_count + 1;
        if (hdr_count == 12) begin
          r.payload_len = plen_word;
          r.image_len = ilen_word;
          hdr_count = 0;
          magic_cnt = 0;
          if (plen_word > lim_payload || ilen_word > lim_image) begin
            r.event_res = bfr_pkg::EV_HDR_REJECT;
            rx_phase = HUNT_MAGIC;
          end else begin
            r.event_res = bfr_pkg::EV_HDR_OK;
            crc_run = bfr_pkg::CRC_INIT;
            byte_count = '0;
            if (plen_word == 0) begin
              r.crc_status = (crc_word == 0) ? bfr_pkg::CRC_GOOD : bfr_pkg::CRC_BAD;
              rx_phase = HUNT_MAGIC;
            end else begin
              rx_phase = TAKE_PAYLOAD;
            end
          end
        end
      end
      TAKE_PAYLOAD: begin
        r.event_res = bfr_pkg::EV_PAYLOAD;
        r.payload_byte = b;
        r.payload_offset = byte_count;
        r.payload_len = plen_word;
        r.image_len = ilen_word;
        crc_run = crc32_update(crc_run, b);
        byte_count = byte_count + 1;
        if (byte_count == plen_word) begin
          r.crc_status = ((~crc_run) == crc_word) ? bfr_pkg::CRC_GOOD : bfr_pkg::CRC_BAD;
          rx_phase = HUNT_MAGIC;
          magic_cnt = 0;
        end
      end
      default: begin
        // a stray 'R' restarts the match at one
        if (b == MAGIC_WORD[8*magic_cnt +: 8]) magic_cnt = magic_cnt + 1;
        else magic_cnt = (b == MAGIC_WORD[7:0]) ? 1 : 0;
        if (magic_cnt == 4) begin
          magic_cnt = 0;
          hdr_count = 0;
          rx_phase = READ_HEADER;
        end
      end
    endcase
    return r;
  endfunction

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left = calm_left - 1;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    mismatches = mismatches + 1;
  endtask

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    pushed = pushed + 1;
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8]);
  endtask

  // whole frame; payload is only sent when the header will pass the limits
  task automatic push_frame(input logic [31:0] plen, input logic [31:0] ilen,
                            input bit crc_ok, input bit extremes);
    logic [7:0] body [$];
    logic [31:0] crc;
    logic [7:0] b;
    crc = bfr_pkg::CRC_INIT;
    if (plen <= lim_payload && ilen <= lim_image) begin
      for (int i = 0; i < plen; i++) begin
        b = extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
        body.push_back(b);
        crc = crc32_update(crc, b);
      end
    end
    crc = ~crc;
    if (!crc_ok) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    push_word(MAGIC_WORD);
    push_word(plen);
    push_word(ilen);
    push_word(crc);
    foreach (body[i]) push_byte(body[i]);
  endtask

  function automatic logic [31:0] pick_len();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = lim_payload;
      2: v = lim_payload + 1;
      3: v = $urandom;
      4: v = $urandom_range(13, 300);
      default: v = $urandom_range(1, 12);
    endcase
    // keep accepted payloads short
    if (v <= lim_payload && v > 300) v = $urandom_range(0, 12);
    return v;
  endfunction

  function automatic logic [31:0] pick_image();
    case ($urandom_range(0, 9))
      0: return lim_image;
      1: return lim_image + 1;
      2: return $urandom;
      3: return 0;
      default: return $urandom_range(0, lim_image);
    endcase
  endfunction

  task automatic random_traffic(input int n_bytes);
    int start;
    int k;
    logic [7:0] b;
    start = pushed;
    while (pushed - start < n_bytes) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
        1: begin
          // broken magic: a true prefix, then a wrong byte
          k = $urandom_range(1, 3);
          for (int i = 0; i < k; i++) push_byte(MAGIC_WORD[8*i +: 8]);
          do b = 8'($urandom); while (b == MAGIC_WORD[8*k +: 8]);
          push_byte(b);
        end
        default: push_frame(pick_len(), pick_image(), $urandom_range(0, 3) != 0, 1'b0);
      endcase
    end
  endtask

  task automatic write_reg(input logic [bfr_pkg::APB_AW-1:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == bfr_pkg::REG_MAX_PAYLOAD) lim_payload = value;
    else lim_image = value;
  endtask

  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(receive_byte(rx_byte));
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() > 0) begin
          rx_byte <= tx_bytes.pop_front();
          in_valid <= 1'b1;
          src_gap = draw_wait(src_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the input side backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_used && bytes_taken >= PRESSURE_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      snk_wait = draw_wait(snk_calm);
      if (snk_wait > 0) begin
        snk_wait = snk_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end else if (snk_wait > 0) begin
      snk_wait = snk_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, event_res", 32'(event_res),
                        32'(bfr_pkg::EV_NONE));
      end else begin
        want = due_results.pop_front();
        if (event_res !== want.event_res)
          report_mismatch("event_res", 32'(event_res), 32'(want.event_res));
        if (crc_status !== want.crc_status)
          report_mismatch("crc_status", 32'(crc_status), 32'(want.crc_status));
        if (payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", 32'(payload_byte), 32'(want.payload_byte));
        if (payload_offset !== want.payload_offset)
          report_mismatch("payload_offset", payload_offset, want.payload_offset);
        if (payload_len !== want.payload_len)
          report_mismatch("payload_len", payload_len, want.payload_len);
        if (image_len !== want.image_len)
          report_mismatch("image_len", image_len, want.image_len);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames at reset limits
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(MAGIC_WORD[7:0]);               // doubled 'R' before the magic
    push_frame(0, 0, 1'b1, 1'b0);             // empty payload, good verdict
    push_byte(MAGIC_WORD[7:0]);
    push_byte(MAGIC_WORD[15:8]);
    push_byte(8'h00);                         // mismatch on a non-R byte
    push_byte(MAGIC_WORD[7:0]);
    push_byte(MAGIC_WORD[15:8]);
    push_byte(MAGIC_WORD[7:0]);               // mismatch on 'R'
    push_frame(0, bfr_pkg::MAX_IMAGE_RST, 1'b0, 1'b0); // empty payload, bad verdict
    push_frame(4, 1, 1'b1, 1'b1);
    push_frame(3, 7, 1'b0, 1'b0);
    push_frame(32'hFFFF_FFFF, 0, 1'b1, 1'b0);
    push_frame(1, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_frame(bfr_pkg::MAX_PAYLOAD_RST + 1, 0, 1'b1, 1'b0);
    push_frame(1, bfr_pkg::MAX_IMAGE_RST + 1, 1'b1, 1'b0);
    push_frame(2, bfr_pkg::MAX_IMAGE_RST, 1'b1, 1'b0);
    random_traffic(200);
    wait_idle();

    write_reg(ADDR_MAX_PAYLOAD, 32'hFFFF_FFFF);
    write_reg(ADDR_MAX_IMAGE, 32'hFFFF_FFFF);
    push_frame(5, 32'hFFFF_FFFF, 1'b1, 1'b0);
    random_traffic(200);
    wait_idle();

    write_reg(ADDR_MAX_PAYLOAD, 32'd0);
    write_reg(ADDR_MAX_IMAGE, 32'd0);
    push_frame(0, 0, 1'b1, 1'b0);
    push_frame(0, 0, 1'b0, 1'b0);
    push_frame(1, 0, 1'b1, 1'b0);
    push_frame(0, 1, 1'b1, 1'b0);
    random_traffic(100);
    wait_idle();

    write_reg(ADDR_MAX_PAYLOAD, 32'd10);
    write_reg(ADDR_MAX_IMAGE, 32'd100);
    push_frame(10, 100, 1'b1, 1'b0);
    push_frame(11, 100, 1'b1, 1'b0);
    push_frame(10, 101, 1'b1, 1'b0);
    random_traffic(200);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/bfr_pkg.sv
hdl/bfr_front.sv
hdl/bfr_queue.sv
hdl/bfr_back.sv
hdl/boot_frame_receiver_top.sv
bench/tb_boot_frame_receiver_top.sv
